[design/bmi_pkg.sv]
package bmi_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_W     = 8;
  localparam int CFG_DATA_W    = 32;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_STEP    = 8'd0,
    CFG_MAX_SPEED    = 8'd1,
    CFG_WORLD_WIDTH  = 8'd2,
    CFG_WORLD_HEIGHT = 8'd3
  } cfg_idx_t;

  localparam logic [30:0] TIME_STEP_RST    = 31'd65536;
  localparam logic [30:0] MAX_SPEED_RST    = 31'd262144;
  localparam logic [14:0] WORLD_WIDTH_RST  = 15'd800;
  localparam logic [14:0] WORLD_HEIGHT_RST = 15'd600;

  typedef struct packed {
    logic [30:0]        pos_x_in;
    logic [30:0]        pos_y_in;
    logic signed [31:0] vel_x_in;
    logic signed [31:0] vel_y_in;
    logic signed [31:0] body_mass;
    logic signed [31:0] steer_force_x;
    logic signed [31:0] steer_force_y;
  } in_t;

  typedef struct packed {
    logic [30:0]        pos_x_out;
    logic [30:0]        pos_y_out;
    logic signed [31:0] vel_x_out;
    logic signed [31:0] vel_y_out;
    logic               speed_clamped;
  } out_t;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // magnitude of a signed 32-bit value, as unsigned
  function automatic logic [31:0] abs32(input logic [31:0] v);
    logic [31:0] r;
    r = v[31] ? (~v + 32'd1) : v;
    return r;
  endfunction

endpackage

[design/bmi_div.sv]
module bmi_div #(
  parameter int NW = 32,
  parameter int DW = 32,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          src_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] rem_init,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side,
  output logic          res_valid,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem,
  output logic [SW-1:0] res_side
);

  // one quotient bit per stage; the numerator register fills with quotient bits
  logic [NW-1:0] nr [NW+1];
  logic [DW-1:0] rr [NW+1];
  logic [DW-1:0] dr [NW+1];
  logic [SW-1:0] sr [NW+1];
  logic          vr [NW+1];

  assign nr[0] = num;
  assign rr[0] = rem_init;
  assign dr[0] = den;
  assign sr[0] = side;
  assign vr[0] = src_valid;

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [DW:0] cur;
    logic [DW:0] diff;
    logic        ge;

    // trial subtract of the divisor
    always_comb begin
      cur  = {rr[i], nr[i][NW-1]};
      diff = cur - {1'b0, dr[i]};
      ge   = cur >= {1'b0, dr[i]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vr[i+1] <= 1'b0;
      end else if (en) begin
        vr[i+1] <= vr[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nr[i+1] <= {nr[i][NW-2:0], ge};
        rr[i+1] <= ge ? diff[DW-1:0] : cur[DW-1:0];
        dr[i+1] <= dr[i];
        sr[i+1] <= sr[i];
      end
    end
  end

  assign res_valid = vr[NW];
  assign quo       = nr[NW];
  assign rem       = rr[NW];
  assign res_side  = sr[NW];

endmodule

[design/boid_motion_integrate_wrap_top.sv]
// One 2D body per request advances by one semi-implicit Euler step.
// Input channel in_valid / in_stall / in_data carries position, velocity,
// mass and steering force; output channel out_valid / out_stall / out_data
// returns the wrapped position, the speed-limited velocity and a flag set
// when the speed was limited. The configuration port (cfg_valid, cfg_ready,
// cfg_index, cfg_data) writes time step, max speed, world width and height;
// cfg_ready is always high and writes belong to times the block is idle.
// The path from acceptance to out_valid runs through the restoring divider
// for acceleration (32 stages), the square root of the speed (32 stages), the
// speed-limit divider (31 stages), the wrap divider (56 - FRAC_BITS stages),
// 11 arithmetic stages and the output register. A new request is taken every
// cycle while the pipeline is not held.
// The whole pipeline advances together: while out_valid is high and
// out_stall is high, every stage holds and in_stall is raised, so nothing is
// lost or repeated. Reset empties the pipeline and loads the register
// defaults (dt 1.0, max speed 4.0, world 800 by 600).
module boid_motion_integrate_wrap_top #(
  parameter int FRAC_BITS = bmi_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bmi_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bmi_pkg::out_t                  out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bmi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bmi_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int TW   = 56 - FRAC_BITS;
  localparam int SQ_N = 32;
  localparam int NAX  = 2;

  typedef struct packed {
    logic [30:0]        pos;
    logic signed [31:0] vel;
    logic               neg;
    logic               ovf;
    logic               fok;
  } sa_t;

  typedef struct packed {
    logic [30:0]        pos;
    logic signed [31:0] vel;
    logic               clamp;
  } sb_t;

  typedef struct packed {
    logic [FRAC_BITS-1:0] low;
    logic                 neg;
    logic signed [31:0]   vel;
    logic                 clamp;
  } sc_t;

  typedef struct packed {
    logic [NAX-1:0][30:0] pos;
    logic [NAX-1:0][31:0] vel;
    logic                 clamp;
  } sq_t;

  logic adv;

  logic [30:0] time_step;
  logic [30:0] max_speed;
  logic [14:0] world_width;
  logic [14:0] world_height;
  logic        dt_pos;
  logic [14:0] units [NAX];

  // whole pipeline advances unless a finished result is held
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      time_step    <= bmi_pkg::TIME_STEP_RST;
      max_speed    <= bmi_pkg::MAX_SPEED_RST;
      world_width  <= bmi_pkg::WORLD_WIDTH_RST;
      world_height <= bmi_pkg::WORLD_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bmi_pkg::CFG_TIME_STEP:    time_step    <= cfg_data[30:0];
        bmi_pkg::CFG_MAX_SPEED:    max_speed    <= cfg_data[30:0];
        bmi_pkg::CFG_WORLD_WIDTH:  world_width  <= cfg_data[14:0];
        bmi_pkg::CFG_WORLD_HEIGHT: world_height <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  assign dt_pos   = |time_step;
  assign units[0] = (world_width == 15'd0) ? 15'd1 : world_width;
  assign units[1] = (world_height == 15'd0) ? 15'd1 : world_height;

  // ---------------- stage 1: capture request ----------------
  logic         v1;
  bmi_pkg::in_t it1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it1 <= in_data;
    end
  end

  // ---------------- acceleration divide: |f| * 2^F / m ----------------
  logic [31:0] a_num   [NAX];
  logic [31:0] a_rinit [NAX];
  logic [31:0] a_den   [NAX];
  sa_t         a_side  [NAX];
  logic [31:0] a_force [NAX];
  logic [31:0] a_abs   [NAX];
  logic [63:0] a_shift [NAX];
  logic        m_pos;

  assign m_pos = !it1.body_mass[31] && (it1.body_mass != 32'sd0);

  always_comb begin
    a_force[0] = it1.steer_force_x;
    a_force[1] = it1.steer_force_y;
    for (int a = 0; a < NAX; a++) begin
      a_abs[a]      = bmi_pkg::abs32(a_force[a]);
      a_shift[a]    = 64'(a_abs[a]) << FRAC_BITS;
      a_den[a]      = m_pos ? it1.body_mass : 32'd1;
      a_side[a].ovf = a_shift[a][63:32] >= a_den[a];
      a_side[a].neg = a_force[a][31];
      a_side[a].fok = dt_pos && m_pos;
      a_rinit[a]    = a_side[a].ovf ? 32'd0 : a_shift[a][63:32];
      a_num[a]      = a_shift[a][31:0];
    end
    a_side[0].pos = it1.pos_x_in;
    a_side[1].pos = it1.pos_y_in;
    a_side[0].vel = it1.vel_x_in;
    a_side[1].vel = it1.vel_y_in;
  end

  logic        a_valid;
  logic [31:0] a_quo [NAX];
  sa_t         a_res [NAX];

  for (genvar ax = 0; ax < NAX; ax++) begin : g_diva
    if (ax == 0) begin : g_v
      bmi_div #(.NW(32), .DW(32), .SW($bits(sa_t))) u_div (
        .clk(clk), .rst(rst), .en(adv), .src_valid(v1),
        .num(a_num[ax]), .rem_init(a_rinit[ax]), .den(a_den[ax]), .side(a_side[ax]),
        .res_valid(a_valid), .quo(a_quo[ax]), .rem(), .res_side(a_res[ax])
      );
    end else begin : g_nv
      bmi_div #(.NW(32), .DW(32), .SW($bits(sa_t))) u_div (
        .clk(clk), .rst(rst), .en(adv), .src_valid(v1),
        .num(a_num[ax]), .rem_init(a_rinit[ax]), .den(a_den[ax]), .side(a_side[ax]),
        .res_valid(), .quo(a_quo[ax]), .rem(), .res_side(a_res[ax])
      );
    end
  end

  // ---------------- stage 2: saturate acceleration ----------------
  logic               v2;
  logic signed [31:0] acc2 [NAX];
  sa_t                s2   [NAX];

  // ---------------- stage 3: acceleration * dt ----------------
  logic               v3;
  logic signed [63:0] prod3 [NAX];
  sa_t                s3    [NAX];
  logic signed [31:0] dt_s;

  assign dt_s = $signed({1'b0, time_step});

  // ---------------- stage 4: velocity update ----------------
  logic               v4;
  logic signed [31:0] vel4 [NAX];
  logic [30:0]        pos4 [NAX];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v2 <= a_valid;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < NAX; a++) begin
        // saturate the quotient, signed by the force
        if (!a_res[a].neg) begin
          acc2[a] <= (a_res[a].ovf || a_quo[a][31]) ? 32'sh7FFF_FFFF : $signed(a_quo[a]);
        end else begin
          acc2[a] <= (a_res[a].ovf || (a_quo[a] > 32'h8000_0000)) ?
                     32'sh8000_0000 : $signed(-a_quo[a]);
        end
        s2[a]    <= a_res[a];
        prod3[a] <= 64'(acc2[a]) * 64'(dt_s);
        s3[a]    <= s2[a];
        vel4[a]  <= s3[a].fok ?
                    bmi_pkg::sat32(64'(s3[a].vel) + (prod3[a] >>> FRAC_BITS)) : s3[a].vel;
        pos4[a]  <= s3[a].pos;
      end
    end
  end

  // ---------------- stages 5 and 6: squared speed and limit ----------------
  logic               v5;
  logic [63:0]        sq5  [NAX];
  logic [63:0]        lim5;
  logic signed [31:0] vel5 [NAX];
  logic [30:0]        pos5 [NAX];

  logic               v6;
  logic [63:0]        mag2_6;
  logic               clamp6;
  logic signed [31:0] vel6 [NAX];
  logic [30:0]        pos6 [NAX];

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lim5   <= 64'(max_speed) * 64'(max_speed);
      mag2_6 <= sq5[0] + sq5[1];
      clamp6 <= (sq5[0] + sq5[1]) > lim5;
      for (int a = 0; a < NAX; a++) begin
        sq5[a]  <= 64'(bmi_pkg::abs32(vel4[a])) * 64'(bmi_pkg::abs32(vel4[a]));
        vel5[a] <= vel4[a];
        pos5[a] <= pos4[a];
        vel6[a] <= vel5[a];
        pos6[a] <= pos5[a];
      end
    end
  end

  // ---------------- square root, two radicand bits per stage ----------------
  logic [63:0] sq_x    [SQ_N+1];
  logic [31:0] sq_root [SQ_N+1];
  logic [33:0] sq_rem  [SQ_N+1];
  logic        sq_v    [SQ_N+1];
  sq_t         sq_s    [SQ_N+1];

  assign sq_x[0]    = mag2_6;
  assign sq_root[0] = '0;
  assign sq_rem[0]  = '0;
  assign sq_v[0]    = v6;

  always_comb begin
    sq_s[0].clamp = clamp6;
    for (int a = 0; a < NAX; a++) begin
      sq_s[0].pos[a] = pos6[a];
      sq_s[0].vel[a] = vel6[a];
    end
  end

  for (genvar i = 0; i < SQ_N; i++) begin : g_sqrt
    logic [35:0] cur;
    logic [35:0] trial;
    logic [35:0] diff;
    logic        ge;

    always_comb begin
      cur   = {sq_rem[i], sq_x[i][63:62]};
      trial = {2'b00, sq_root[i], 2'b01};
      diff  = cur - trial;
      ge    = cur >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[i+1] <= 1'b0;
      end else if (adv) begin
        sq_v[i+1] <= sq_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_x[i+1]    <= {sq_x[i][61:0], 2'b00};
        sq_root[i+1] <= {sq_root[i][30:0], ge};
        sq_rem[i+1]  <= ge ? diff[33:0] : cur[33:0];
        sq_s[i+1]    <= sq_s[i];
      end
    end
  end

  // ---------------- stage 7: ceiling of root, |v| * max_speed ----------------
  logic        v7;
  logic [32:0] mag7;
  logic [62:0] pv7 [NAX];
  sb_t         s7  [NAX];

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (adv) begin
      v7 <= sq_v[SQ_N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag7 <= {1'b0, sq_root[SQ_N]} + 33'(sq_rem[SQ_N] != 34'd0);
      for (int a = 0; a < NAX; a++) begin
        pv7[a]      <= 63'(bmi_pkg::abs32(sq_s[SQ_N].vel[a])) * 63'(max_speed);
        s7[a].pos   <= sq_s[SQ_N].pos[a];
        s7[a].vel   <= $signed(sq_s[SQ_N].vel[a]);
        s7[a].clamp <= sq_s[SQ_N].clamp;
      end
    end
  end

  // ---------------- speed-limit divide: |v| * max_speed / mag ----------------
  logic [30:0] b_num   [NAX];
  logic [32:0] b_rinit [NAX];
  logic [32:0] b_den   [NAX];

  // quotient stays below 2^31, so the high part seeds the remainder
  always_comb begin
    for (int a = 0; a < NAX; a++) begin
      b_num[a]   = s7[a].clamp ? pv7[a][30:0] : 31'd0;
      b_rinit[a] = s7[a].clamp ? {1'b0, pv7[a][62:31]} : 33'd0;
      b_den[a]   = s7[a].clamp ? mag7 : 33'd1;
    end
  end

  logic        b_valid;
  logic [30:0] b_quo [NAX];
  sb_t         b_res [NAX];

  for (genvar ax = 0; ax < NAX; ax++) begin : g_divb
    if (ax == 0) begin : g_v
      bmi_div #(.NW(31), .DW(33), .SW($bits(sb_t))) u_div (
        .clk(clk), .rst(rst), .en(adv), .src_valid(v7),
        .num(b_num[ax]), .rem_init(b_rinit[ax]), .den(b_den[ax]), .side(s7[ax]),
        .res_valid(b_valid), .quo(b_quo[ax]), .rem(), .res_side(b_res[ax])
      );
    end else begin : g_nv
      bmi_div #(.NW(31), .DW(33), .SW($bits(sb_t))) u_div (
        .clk(clk), .rst(rst), .en(adv), .src_valid(v7),
        .num(b_num[ax]), .rem_init(b_rinit[ax]), .den(b_den[ax]), .side(s7[ax]),
        .res_valid(), .quo(b_quo[ax]), .rem(), .res_side(b_res[ax])
      );
    end
  end

  // ---------------- stages 8 to 11: limited velocity, position sum ----------------
  logic               v8;
  logic signed [31:0] vel8 [NAX];
  logic [30:0]        pos8 [NAX];
  logic               clamp8;

  logic               v9;
  logic signed [63:0] prod9 [NAX];
  logic signed [31:0] vel9  [NAX];
  logic [30:0]        pos9  [NAX];
  logic               clamp9;

  logic               v10;
  logic signed [63:0] s10   [NAX];
  logic signed [31:0] vel10 [NAX];
  logic               clamp10;

  logic               v11;
  logic [TW-1:0]      tabs11 [NAX];
  sc_t                s11    [NAX];

  logic signed [63:0] t10  [NAX];
  logic signed [63:0] tn10 [NAX];

  // whole-unit part of the sum, floor shifted, and its magnitude
  always_comb begin
    for (int a = 0; a < NAX; a++) begin
      t10[a]  = s10[a] >>> FRAC_BITS;
      tn10[a] = -t10[a];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v8  <= 1'b0;
      v9  <= 1'b0;
      v10 <= 1'b0;
      v11 <= 1'b0;
    end else if (adv) begin
      v8  <= b_valid;
      v9  <= v8;
      v10 <= v9;
      v11 <= v10;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      clamp8  <= b_res[0].clamp;
      clamp9  <= clamp8;
      clamp10 <= clamp9;
      for (int a = 0; a < NAX; a++) begin
        if (b_res[a].clamp) begin
          vel8[a] <= b_res[a].vel[31] ? -$signed({1'b0, b_quo[a]}) : $signed({1'b0, b_quo[a]});
        end else begin
          vel8[a] <= b_res[a].vel;
        end
        pos8[a]  <= b_res[a].pos;
        prod9[a] <= 64'(vel8[a]) * 64'(dt_s);
        vel9[a]  <= vel8[a];
        pos9[a]  <= pos8[a];
        s10[a]   <= $signed({33'd0, pos9[a]}) + (prod9[a] >>> FRAC_BITS);
        vel10[a] <= vel9[a];
        tabs11[a]      <= t10[a][63] ? tn10[a][TW-1:0] : t10[a][TW-1:0];
        s11[a].low     <= s10[a][FRAC_BITS-1:0];
        s11[a].neg     <= t10[a][63];
        s11[a].vel     <= vel10[a];
        s11[a].clamp   <= clamp10;
      end
    end
  end

  // ---------------- wrap divide: whole units modulo world size ----------------
  logic        c_valid;
  logic [14:0] c_rem [NAX];
  sc_t         c_res [NAX];

  for (genvar ax = 0; ax < NAX; ax++) begin : g_divc
    if (ax == 0) begin : g_v
      bmi_div #(.NW(TW), .DW(15), .SW($bits(sc_t))) u_div (
        .clk(clk), .rst(rst), .en(adv), .src_valid(v11),
        .num(tabs11[ax]), .rem_init(15'd0), .den(units[ax]), .side(s11[ax]),
        .res_valid(c_valid), .quo(), .rem(c_rem[ax]), .res_side(c_res[ax])
      );
    end else begin : g_nv
      bmi_div #(.NW(TW), .DW(15), .SW($bits(sc_t))) u_div (
        .clk(clk), .rst(rst), .en(adv), .src_valid(v11),
        .num(tabs11[ax]), .rem_init(15'd0), .den(units[ax]), .side(s11[ax]),
        .res_valid(), .quo(), .rem(c_rem[ax]), .res_side(c_res[ax])
      );
    end
  end

  // ---------------- output register ----------------
  logic [14:0] wr   [NAX];
  logic [63:0] wpos [NAX];

  // fold a negative sum back into range, then rejoin the fraction
  always_comb begin
    for (int a = 0; a < NAX; a++) begin
      wr[a]   = (c_res[a].neg && (c_rem[a] != 15'd0)) ? (units[a] - c_rem[a]) : c_rem[a];
      wpos[a] = (64'(wr[a]) << FRAC_BITS) | 64'(c_res[a].low);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.pos_x_out     <= wpos[0][30:0];
      out_data.pos_y_out     <= wpos[1][30:0];
      out_data.vel_x_out     <= c_res[0].vel;
      out_data.vel_y_out     <= c_res[1].vel;
      out_data.speed_clamped <= c_res[0].clamp;
    end
  end

endmodule

[tb/sv/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = bmi_pkg::FRAC_BITS_DEF;
  localparam int LATENCY = 163 - FRAC;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  bmi_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  bmi_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bmi_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bmi_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // register copies used for prediction
  longint unsigned dt_reg, speed_reg, width_reg, height_reg;

  bmi_pkg::out_t expected_steps[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  boid_motion_integrate_wrap_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic longint clip32(longint v);
    longint r;
    r = v;
    if (v > 64'sd2147483647) r = 64'sd2147483647;
    if (v < -64'sd2147483648) r = -64'sd2147483648;
    return r;
  endfunction

  // ceiling of the square root of a 64-bit value
  function automatic longint unsigned root_up(longint unsigned x);
    longint unsigned r, b, y;
    r = 0;
    b = 64'd1 << 62;
    y = x;
    while (b > y) b = b >> 2;
    while (b != 0) begin
      if (y >= r + b) begin
        y = y - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (r * r < x) r++;
    return r;
  endfunction

  function automatic longint unsigned torus_wrap(longint s, longint unsigned units);
    longint span, r;
    if (units == 0) units = 1;
    span = longint'(units << FRAC);
    r = s % span;
    if (r < 0) r += span;
    return longint'(r) & 64'h7FFF_FFFF;
  endfunction

  // one Euler step of the body under the current registers
  function automatic bmi_pkg::out_t euler_step(bmi_pkg::in_t b);
    bmi_pkg::out_t o;
    longint px, py, vx, vy, m, fx, fy, dt, ms, ax, ay, mag;
    longint unsigned mag2, lim2;
    px = longint'(b.pos_x_in);
    py = longint'(b.pos_y_in);
    vx = longint'(b.vel_x_in);
    vy = longint'(b.vel_y_in);
    m = longint'(b.body_mass);
    fx = longint'(b.steer_force_x);
    fy = longint'(b.steer_force_y);
    dt = longint'(dt_reg);
    ms = longint'(speed_reg);
    o = '0;
    if (dt > 0 && m > 0) begin
      ax = clip32((fx <<< FRAC) / m);
      ay = clip32((fy <<< FRAC) / m);
      vx = clip32(vx + ((ax * dt) >>> FRAC));
      vy = clip32(vy + ((ay * dt) >>> FRAC));
    end
    mag2 = longint'(vx * vx) + longint'(vy * vy);
    lim2 = longint'(ms * ms);
    if (mag2 > lim2) begin
      mag = longint'(root_up(mag2));
      vx = (vx * ms) / mag;
      vy = (vy * ms) / mag;
      o.speed_clamped = 1'b1;
    end
    px = px + ((vx * dt) >>> FRAC);
    py = py + ((vy * dt) >>> FRAC);
    o.pos_x_out = 31'(torus_wrap(px, width_reg));
    o.pos_y_out = 31'(torus_wrap(py, height_reg));
    o.vel_x_out = vx[31:0];
    o.vel_y_out = vy[31:0];
    return o;
  endfunction

  // random receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // compare each delivered step with the oldest prediction
  always @(posedge clk) begin
    bmi_pkg::out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_steps.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, out_data);
      end else begin
        want = expected_steps.pop_front();
        if (out_data.pos_x_out !== want.pos_x_out) begin
          errors++;
          $display("%0t: pos_x exp %h got %h", $time, want.pos_x_out, out_data.pos_x_out);
        end
        if (out_data.pos_y_out !== want.pos_y_out) begin
          errors++;
          $display("%0t: pos_y exp %h got %h", $time, want.pos_y_out, out_data.pos_y_out);
        end
        if (out_data.vel_x_out !== want.vel_x_out) begin
          errors++;
          $display("%0t: vel_x exp %h got %h", $time, want.vel_x_out, out_data.vel_x_out);
        end
        if (out_data.vel_y_out !== want.vel_y_out) begin
          errors++;
          $display("%0t: vel_y exp %h got %h", $time, want.vel_y_out, out_data.vel_y_out);
        end
        if (out_data.speed_clamped !== want.speed_clamped) begin
          errors++;
          $display("%0t: clamp exp %b got %b", $time, want.speed_clamped,
                   out_data.speed_clamped);
        end
      end
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  // drive one request and hold it until taken
  task automatic send_body(bmi_pkg::in_t b);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = b;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !in_stall;
      if (taken) expected_steps.push_back(euler_step(b));
      @(negedge clk);
    end
    in_valid = 1'b0;
  endtask

  // write a register once the pipeline has drained
  task automatic write_reg(bmi_pkg::cfg_idx_t idx, logic [31:0] value);
    bit done;
    while (expected_steps.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    done = 1'b0;
    while (!done) begin
      @(posedge clk);
      done = cfg_ready;
      if (done) begin
        case (idx)
          bmi_pkg::CFG_TIME_STEP:    dt_reg = 64'(value[30:0]);
          bmi_pkg::CFG_MAX_SPEED:    speed_reg = 64'(value[30:0]);
          bmi_pkg::CFG_WORLD_WIDTH:  width_reg = 64'(value[14:0]);
          bmi_pkg::CFG_WORLD_HEIGHT: height_reg = 64'(value[14:0]);
          default: ;
        endcase
      end
      @(negedge clk);
    end
    cfg_valid = 1'b0;
  endtask

  function automatic logic [31:0] pick_word();
    logic [31:0] w;
    case ($urandom_range(5))
      0: w = 32'h7FFF_FFFF;
      1: w = 32'h8000_0000;
      2: w = $urandom_range(4095) - 2048;
      3: w = ($urandom & 32'h000F_FFFF) - 32'h0008_0000;
      default: w = $urandom;
    endcase
    return w;
  endfunction

  // random body, mostly sensible mass and position
  function automatic bmi_pkg::in_t random_body();
    bmi_pkg::in_t b;
    b.pos_x_in = 31'(($urandom_range(9) == 0) ? $urandom :
                     $urandom_range(32'(width_reg << FRAC)));
    b.pos_y_in = 31'(($urandom_range(9) == 0) ? $urandom :
                     $urandom_range(32'(height_reg << FRAC)));
    b.vel_x_in = ($urandom_range(3) == 0) ? pick_word() : $urandom_range(20'hF_FFFF) - 20'h8_0000;
    b.vel_y_in = ($urandom_range(3) == 0) ? pick_word() : $urandom_range(20'hF_FFFF) - 20'h8_0000;
    case ($urandom_range(5))
      0: b.body_mass = pick_word();
      1: b.body_mass = -$urandom_range(1 << 20);
      default: b.body_mass = $urandom_range(32'h0100_0000, 1);
    endcase
    b.steer_force_x = pick_word();
    b.steer_force_y = pick_word();
    return b;
  endfunction

  function automatic bmi_pkg::in_t make_body(logic [30:0] px, logic [30:0] py, logic [31:0] vx,
                                             logic [31:0] vy, logic [31:0] m, logic [31:0] fx,
                                             logic [31:0] fy);
    bmi_pkg::in_t b;
    b = '{px, py, vx, vy, m, fx, fy};
    return b;
  endfunction

  task automatic test_directed_extremes();
    send_body(make_body(0, 0, 0, 0, 0, 0, 0));
    send_body(make_body(31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                        32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    send_body(make_body(100, 200, 32'h8000_0000, 32'h8000_0000, 1, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF));
    send_body(make_body(5 << 16, 5 << 16, 32'h0001_0000, 0, 32'hFFFF_FFFF,
                        32'h0001_0000, 0));
    send_body(make_body(5 << 16, 5 << 16, 32'h0001_0000, 32'h0001_0000, 32'h8000_0000,
                        32'h0001_0000, 32'h0001_0000));
    send_body(make_body(1, 1, 32'h0003_0000, 32'h0004_0000, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h7FFF_FFFF));
    send_body(make_body(0, 0, 32'hFFFF_0000, 32'hFFFF_0000, 32'h0002_0000,
                        32'hFFFF_0000, 32'h0001_0000));
    send_body(make_body(799 << 16, 599 << 16, 32'h0002_0000, 32'h0002_0000,
                        32'h0001_0000, 0, 0));
  endtask

  task automatic test_register_extremes();
    write_reg(bmi_pkg::CFG_TIME_STEP, 0);
    send_body(make_body(3 << 16, 3 << 16, 32'h0010_0000, 32'hFFF0_0000, 32'h0001_0000,
                        32'h7FFF_FFFF, 32'h8000_0000));
    write_reg(bmi_pkg::CFG_MAX_SPEED, 0);
    write_reg(bmi_pkg::CFG_TIME_STEP, 32'h0001_0000);
    send_body(make_body(3 << 16, 3 << 16, 1, 0, 32'h0001_0000, 0, 0));
    send_body(make_body(3 << 16, 3 << 16, 0, 0, 0, 0, 0));
    write_reg(bmi_pkg::CFG_WORLD_WIDTH, 0);
    write_reg(bmi_pkg::CFG_WORLD_HEIGHT, 0);
    write_reg(bmi_pkg::CFG_MAX_SPEED, 32'h7FFF_FFFF);
    send_body(make_body(31'h7FFF_FFFF, 12345, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF));
    write_reg(bmi_pkg::CFG_TIME_STEP, 32'h7FFF_FFFF);
    write_reg(bmi_pkg::CFG_WORLD_WIDTH, 32'h7FFF);
    write_reg(bmi_pkg::CFG_WORLD_HEIGHT, 32'h7FFF);
    send_body(make_body(31'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h8000_0000, 1,
                        32'h7FFF_FFFF, 32'h8000_0000));
    send_body(make_body(0, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 1, 32'h0000_8000, 1, 32'hFFFF_FFFF));
    write_reg(bmi_pkg::CFG_WORLD_WIDTH, 1);
    write_reg(bmi_pkg::CFG_WORLD_HEIGHT, 1);
    send_body(make_body(31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                        32'h0001_0000, 0, 0));
  endtask

  // random bodies under a random but plausible register setting
  task automatic test_random_phase(int idle_pct, int stall_pct, int count);
    int i;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (i = 0; i < count; i++) begin
      if (i % 160 == 0) begin
        write_reg(bmi_pkg::CFG_TIME_STEP,
                  ($urandom_range(7) == 0) ? 0 : $urandom_range(32'h0004_0000));
        write_reg(bmi_pkg::CFG_MAX_SPEED,
                  ($urandom_range(7) == 0) ? $urandom : $urandom_range(32'h0020_0000));
        write_reg(bmi_pkg::CFG_WORLD_WIDTH, ($urandom_range(7) == 0) ?
                  $urandom_range(32767) : $urandom_range(2000, 1));
        write_reg(bmi_pkg::CFG_WORLD_HEIGHT, ($urandom_range(7) == 0) ?
                  $urandom_range(32767) : $urandom_range(2000, 1));
      end
      send_body(random_body());
    end
  endtask

  initial begin
    dt_reg = 64'(bmi_pkg::TIME_STEP_RST);
    speed_reg = 64'(bmi_pkg::MAX_SPEED_RST);
    width_reg = 64'(bmi_pkg::WORLD_WIDTH_RST);
    height_reg = 64'(bmi_pkg::WORLD_HEIGHT_RST);
    repeat (11) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);
    send_idle_pct = 16;
    recv_stall_pct = 60;
    test_directed_extremes();
    test_register_extremes();
    test_random_phase(16, 60, 640);
    test_random_phase(60, 16, 640);
    test_random_phase(0, 0, 640);
    while (expected_steps.size() != 0) @(negedge clk);
    repeat (LATENCY + 20) @(negedge clk);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
